// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL datapath
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/mfa_pkg.sv
// ---------------------------------------------------------------------------
// mfa_pkg
// Shared constants, state encoding and controller/datapath structs for the
// max-flow block.
// ---------------------------------------------------------------------------
package mfa_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int CAP_BITS_DEF     = 16;
	localparam int VC_W             = 5;
	localparam int CAP_IN_W         = 16;
	localparam int FLOW_W           = 20;

	localparam logic [VC_W-1:0]   VC_RESET = 5'd16;
	localparam logic [FLOW_W-1:0] FLOW_MAX = 20'hFFFFF;

	// controller states
	typedef enum logic [3:0] {
		S_LOAD,
		S_REDIV,
		S_INIT,
		S_POP,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_BN_RD,
		S_BN_CHK,
		S_UP_RDF,
		S_UP_WRF,
		S_UP_RDR,
		S_UP_WRR,
		S_ADD,
		S_FINISH
	} state_t;

	// residual read address select
	typedef enum logic [1:0] {
		RD_SCAN,
		RD_FWD,
		RD_REV
	} rsel_t;

	// commands, controller -> datapath
	typedef struct packed {
		logic  load;
		logic  last;
		logic  div_step;
		logic  bfs_init;
		logic  pop;
		logic  scan_chk;
		logic  walk_rst;
		logic  bn_init;
		logic  bn_chk;
		logic  wr_fwd;
		logic  wr_rev;
		logic  walk_next;
		logic  flow_add;
		logic  out_load;
		rsel_t rd_sel;
	} cmd_t;

	// status, datapath -> controller
	typedef struct packed {
		logic div_pend;
		logic div_done;
		logic q_empty;
		logic hit;
		logic v_is_sink;
		logic par_is_src;
		logic out_free;
	} status_t;

endpackage

// File: hw/rtl/mfa_item_if.sv
// ---------------------------------------------------------------------------
// mfa_item_if
// Input channel: one capacity matrix entry per word.
// ---------------------------------------------------------------------------
interface mfa_item_if;
	import mfa_pkg::*;

	logic                valid;
	logic                ready;
	logic [CAP_IN_W-1:0] capacity;
	logic                last_entry;

	modport source (output valid, output capacity, output last_entry, input ready);
	modport sink (input valid, input capacity, input last_entry, output ready);
endinterface

// File: hw/rtl/mfa_result_if.sv
// ---------------------------------------------------------------------------
// mfa_result_if
// Output channel: one max-flow total per word.
// ---------------------------------------------------------------------------
interface mfa_result_if;
	import mfa_pkg::*;

	logic              valid;
	logic              ready;
	logic [FLOW_W-1:0] flow_sum;

	modport source (output valid, output flow_sum, input ready);
	modport sink (input valid, input flow_sum, output ready);
endinterface

// File: hw/rtl/max_flow_bfs_augmenting.sv
// Loading: one matrix word per cycle, stalled while the position is re-split after a
// vertex count write. The last word starts the search: a pop per dequeued vertex, a read
// and a check per scanned residual entry and per bottleneck path edge, forward and reverse
// reads and writes per updated path edge, and an init and an add step per path found.
// Throughput: one result per matrix; total time is data dependent.
// Reset: arst_n clears control and flow and sets the vertex count to 16; residual memory is not cleared.
// ---------------------------------------------------------------------------
// max_flow_bfs_augmenting
// Max-flow engine using breadth-first augmenting paths over a stored
// residual capacity matrix.
// ---------------------------------------------------------------------------
module max_flow_bfs_augmenting #(
	parameter int MAX_VERTICES = mfa_pkg::MAX_VERTICES_DEF,
	parameter int CAP_BITS     = mfa_pkg::CAP_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [mfa_pkg::VC_W-1:0] cfg_wdata,
	mfa_item_if.sink                 matrix,
	mfa_result_if.source             result
);
	import mfa_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    item_ready;

	assign matrix.ready = item_ready;

	// sequencer
	mfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (matrix.valid),
		.item_last  (matrix.last_entry),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath
	mfa_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.CAP_BITS     (CAP_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.capacity  (matrix.capacity),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.flow_sum  (result.flow_sum),
		.st        (st)
	);

endmodule

// File: hw/rtl/mfa_ctrl.sv
// ---------------------------------------------------------------------------
// mfa_ctrl
// Sequencer: matrix load and position re-split, BFS scan, bottleneck walk, residual
// update and result hand-off.
// ---------------------------------------------------------------------------
module mfa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_last,
	output logic             item_ready,
	input  mfa_pkg::status_t st,
	output mfa_pkg::cmd_t    cmd
);
	import mfa_pkg::*;

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_LOAD: begin
				if (st.div_pend) begin
					state_nx = S_REDIV;
				end else if (item_valid && item_last) begin
					state_nx = S_INIT;
				end
			end
			S_REDIV: begin
				if (st.div_done) state_nx = S_LOAD;
			end
			S_INIT:    state_nx = S_POP;
			S_POP:     state_nx = st.q_empty ? S_FINISH : S_SCAN_RD;
			S_SCAN_RD: state_nx = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (st.hit && st.v_is_sink) begin
					state_nx = S_BN_RD;
				end else if (st.v_is_sink) begin
					state_nx = S_POP;
				end else begin
					state_nx = S_SCAN_RD;
				end
			end
			S_BN_RD:   state_nx = S_BN_CHK;
			S_BN_CHK:  state_nx = st.par_is_src ? S_UP_RDF : S_BN_RD;
			S_UP_RDF:  state_nx = S_UP_WRF;
			S_UP_WRF:  state_nx = S_UP_RDR;
			S_UP_RDR:  state_nx = S_UP_WRR;
			S_UP_WRR:  state_nx = st.par_is_src ? S_ADD : S_UP_RDF;
			S_ADD:     state_nx = S_INIT;
			S_FINISH: begin
				if (st.out_free) state_nx = S_LOAD;
			end
			default:   state_nx = S_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_SCAN;
		item_ready = 1'b0;
		case (state_q)
			S_LOAD: begin
				item_ready = !st.div_pend;
				cmd.load   = item_valid && !st.div_pend;
				cmd.last   = item_valid && !st.div_pend && item_last;
			end
			S_REDIV:    cmd.div_step = 1'b1;
			S_INIT:     cmd.bfs_init = 1'b1;
			S_POP:      cmd.pop = !st.q_empty;
			S_SCAN_RD:  cmd.rd_sel = RD_SCAN;
			S_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				cmd.walk_rst = st.hit && st.v_is_sink;
				cmd.bn_init  = st.hit && st.v_is_sink;
			end
			S_BN_RD:    cmd.rd_sel = RD_FWD;
			S_BN_CHK: begin
				cmd.bn_chk   = 1'b1;
				cmd.walk_rst = st.par_is_src;
			end
			S_UP_RDF:   cmd.rd_sel = RD_FWD;
			S_UP_WRF:   cmd.wr_fwd = 1'b1;
			S_UP_RDR:   cmd.rd_sel = RD_REV;
			S_UP_WRR: begin
				cmd.wr_rev    = 1'b1;
				cmd.walk_next = 1'b1;
			end
			S_ADD:      cmd.flow_add = 1'b1;
			S_FINISH:   cmd.out_load = st.out_free;
			default:    cmd = '0;
		endcase
	end

endmodule

// File: hw/rtl/mfa_dp.sv
// ---------------------------------------------------------------------------
// mfa_dp
// Datapath: residual capacity memory, load counters, BFS queue and parents,
// bottleneck and flow registers, result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mfa_dp #(
	parameter int MAX_VERTICES = mfa_pkg::MAX_VERTICES_DEF,
	parameter int CAP_BITS     = mfa_pkg::CAP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mfa_pkg::VC_W-1:0]     cfg_wdata,
	input  mfa_pkg::cmd_t                cmd,
	input  logic [mfa_pkg::CAP_IN_W-1:0] capacity,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [mfa_pkg::FLOW_W-1:0]   flow_sum,
	output mfa_pkg::status_t             st
);
	import mfa_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int PW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
	localparam int RW = CAP_BITS + 1;
	localparam int AW = 2 * VW;
	localparam int CW = (NW > VC_W) ? NW : VC_W;
	localparam int CB = (CAP_BITS < CAP_IN_W) ? CAP_BITS : CAP_IN_W;
	localparam int SW = (CAP_BITS + 2 > FLOW_W + 1) ? CAP_BITS + 2 : FLOW_W + 1;

	logic [VC_W-1:0]   vc_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     row_q;
	logic [PW-1:0]     col_q;
	logic              div_pend_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [VW-1:0]     parent_q [MAX_VERTICES];
	logic [VW-1:0]     queue_q [MAX_VERTICES];
	logic [NW-1:0]     head_q, tail_q;
	logic [VW-1:0]     u_q, v_q, w_q;
	logic [RW-1:0]     bn_q;
	logic [FLOW_W-1:0] flow_q;
	logic [RW-1:0]     rd_q;
	logic              res_valid_q;
	logic [FLOW_W-1:0] res_data_q;

	logic [RW-1:0]     mem [2**AW];

	logic [CW-1:0]     vc_ext;
	logic [NW-1:0]     n_w;
	logic [VW-1:0]     sink_w;
	logic [VW-1:0]     par_w;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [RW-1:0]     wr_data;
	logic              wr_en;
	logic              row_ok;
	logic              hit_w;
	logic [SW-1:0]     sum_w;

	// active vertex count, clamped to [2, MAX_VERTICES]
	always_comb begin
		vc_ext = CW'(vc_q);
		if (vc_ext < CW'(2)) begin
			n_w = NW'(2);
		end else if (vc_ext > CW'(MAX_VERTICES)) begin
			n_w = NW'(MAX_VERTICES);
		end else begin
			n_w = NW'(vc_ext);
		end
	end

	assign sink_w = VW'(n_w - NW'(1));
	assign par_w  = parent_q[w_q];
	assign row_ok = row_q < PW'(n_w);
	assign hit_w  = !visited_q[v_q] && (rd_q != '0);
	assign sum_w  = SW'(flow_q) + SW'(bn_q);

	// residual memory port muxing
	always_comb begin
		case (cmd.rd_sel)
			RD_SCAN: rd_addr = {u_q, v_q};
			RD_FWD:  rd_addr = {par_w, w_q};
			RD_REV:  rd_addr = {w_q, par_w};
			default: rd_addr = {u_q, v_q};
		endcase
		wr_en   = 1'b0;
		wr_addr = {row_q[VW-1:0], col_q[VW-1:0]};
		wr_data = RW'(capacity[CB-1:0]);
		if (cmd.load && row_ok) begin
			wr_en = 1'b1;
		end else if (cmd.wr_fwd) begin
			wr_en   = 1'b1;
			wr_addr = {par_w, w_q};
			wr_data = rd_q - bn_q;
		end else if (cmd.wr_rev) begin
			wr_en   = 1'b1;
			wr_addr = {w_q, par_w};
			wr_data = rd_q + bn_q;
		end
	end

	// residual memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// load position, row/column split, config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q       <= VC_RESET;
			pos_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			div_pend_q <= 1'b0;
		end else if (cfg_we) begin
			vc_q       <= cfg_wdata;
			row_q      <= '0;
			col_q      <= pos_q;
			div_pend_q <= 1'b1;
		end else begin
			if (cmd.load) begin
				if (cmd.last) begin
					pos_q <= '0;
					row_q <= '0;
					col_q <= '0;
				end else if (row_ok) begin
					pos_q <= pos_q + PW'(1);
					if (col_q == PW'(n_w - NW'(1))) begin
						col_q <= '0;
						row_q <= row_q + PW'(1);
					end else begin
						col_q <= col_q + PW'(1);
					end
				end
			end
			// re-split position by repeated subtraction after n changes
			if (cmd.div_step) begin
				if (col_q >= PW'(n_w)) begin
					col_q <= col_q - PW'(n_w);
					row_q <= row_q + PW'(1);
				end else begin
					div_pend_q <= 1'b0;
				end
			end
		end
	end

	// BFS control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			flow_q    <= '0;
		end else begin
			if (cmd.bfs_init) begin
				visited_q    <= MAX_VERTICES'(1);
				head_q       <= '0;
				tail_q       <= NW'(1);
			end
			if (cmd.pop) head_q <= head_q + NW'(1);
			if (cmd.scan_chk && hit_w && (v_q != sink_w)) begin
				visited_q[v_q] <= 1'b1;
				if (tail_q < NW'(MAX_VERTICES)) tail_q <= tail_q + NW'(1);
			end
			if (cmd.last) flow_q <= '0;
			if (cmd.flow_add) begin
				if (sum_w > SW'(FLOW_MAX)) begin
					flow_q <= FLOW_MAX;
				end else begin
					flow_q <= FLOW_W'(sum_w);
				end
			end
		end
	end

	// queue, parents, walk and bottleneck payload
	always_ff @(posedge clk) begin
		if (cmd.bfs_init) begin
			queue_q[0]  <= '0;
			parent_q[0] <= '0;
		end
		if (cmd.pop) begin
			u_q <= queue_q[head_q[VW-1:0]];
			v_q <= '0;
		end
		if (cmd.scan_chk) begin
			v_q <= v_q + VW'(1);
			if (hit_w) begin
				parent_q[v_q] <= u_q;
				if ((v_q != sink_w) && (tail_q < NW'(MAX_VERTICES))) begin
					queue_q[tail_q[VW-1:0]] <= v_q;
				end
			end
		end
		if (cmd.bn_init) bn_q <= '1;
		if (cmd.bn_chk) begin
			if (rd_q < bn_q) bn_q <= rd_q;
		end
		// walk pointer: back to the sink, or one step toward the source
		if (cmd.walk_rst) begin
			w_q <= sink_w;
		end else if (cmd.bn_chk || cmd.walk_next) begin
			w_q <= par_w;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) res_data_q <= flow_q;
	end

	assign out_valid = res_valid_q;
	assign flow_sum  = res_data_q;

	// status
	assign st.div_pend   = div_pend_q;
	assign st.div_done   = col_q < PW'(n_w);
	assign st.q_empty    = head_q == tail_q;
	assign st.hit        = hit_w;
	assign st.v_is_sink  = v_q == sink_w;
	assign st.par_is_src = par_w == '0;
	assign st.out_free   = !res_valid_q || out_ready;

	`ASSERT_IMPL(a_queue_order, clk, arst_n, 1'b1, head_q <= tail_q)
	`ASSERT_IMPL(a_out_free, clk, arst_n, cmd.out_load, !res_valid_q || out_ready)
	`ASSERT_NEXT(a_flow_grows, clk, arst_n, cmd.flow_add, flow_q >= $past(flow_q))

endmodule

// File: dv/max_flow_bfs_augmenting_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// max_flow_bfs_augmenting_checker
// Watches the matrix and result channels and the vertex count register,
// keeps its own residual matrix, predicts each max-flow total with a
// breadth-first augmenting search and compares it with the block's word.
// ---------------------------------------------------------------------------
module max_flow_bfs_augmenting_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [mfa_pkg::VC_W-1:0] cfg_wdata,
	mfa_item_if                      item_bus,
	mfa_result_if                    flow_bus,
	output int                       mismatches,
	output int                       pending
);
	import mfa_pkg::*;

	localparam int NV = MAX_VERTICES_DEF;

	int unsigned         resid [NV][NV];
	int unsigned         parent [NV];
	logic [VC_W-1:0]     vcount;
	int unsigned         load_pos;
	logic [FLOW_W-1:0]   flow_expected [$];

	function automatic int unsigned used_vertices();
		int unsigned n;
		n = vcount;
		if (n < 2) n = 2;
		if (n > NV) n = NV;
		return n;
	endfunction

	// shortest path from vertex 0 to the sink; fills parent[]
	function automatic bit find_route(int unsigned n);
		bit          seen [NV];
		int unsigned fifo [NV];
		int unsigned head, tail, u;
		head = 0;
		tail = 0;
		foreach (seen[i]) seen[i] = 1'b0;
		fifo[tail++] = 0;
		seen[0] = 1'b1;
		parent[0] = 0;
		while (head < tail) begin
			u = fifo[head++];
			for (int unsigned v = 0; v < n; v++) begin
				if (!seen[v] && resid[u][v] > 0) begin
					parent[v] = u;
					if (v == n - 1) return 1'b1;
					seen[v] = 1'b1;
					if (tail < NV) fifo[tail++] = v;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [FLOW_W-1:0] solve_max_flow(int unsigned n);
		longint unsigned total;
		int unsigned     neck, v, u;
		total = 0;
		while (find_route(n)) begin
			neck = 32'hFFFF_FFFF;
			for (v = n - 1; v != 0; v = parent[v])
				if (resid[parent[v]][v] < neck) neck = resid[parent[v]][v];
			for (v = n - 1; v != 0; v = parent[v]) begin
				u = parent[v];
				resid[u][v] -= neck;
				resid[v][u] += neck;
			end
			total += neck;
			if (total > FLOW_MAX) total = FLOW_MAX;
		end
		return total[FLOW_W-1:0];
	endfunction

	// predict on matrix words, compare on result words
	always @(posedge clk or negedge arst_n) begin
		int unsigned       n;
		logic [FLOW_W-1:0] want;
		if (!arst_n) begin
			vcount     <= VC_RESET;
			load_pos   = 0;
			mismatches = 0;
			pending    = 0;
			flow_expected.delete();
		end else begin
			if (item_bus.valid && item_bus.ready) begin
				n = used_vertices();
				if (load_pos < n * n) begin
					resid[load_pos / n][load_pos % n] = item_bus.capacity;
					load_pos++;
				end
				if (item_bus.last_entry) begin
					flow_expected = {flow_expected, solve_max_flow(n)};
					load_pos = 0;
				end
			end
			if (flow_bus.valid && flow_bus.ready) begin
				if (flow_expected.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result word %0d with nothing expected",
							$realtime, flow_bus.flow_sum);
					mismatches++;
				end else begin
					want = flow_expected.pop_front();
					if (flow_bus.flow_sum !== want) begin
						if (mismatches < 10)
							$display("%0t: flow total expected %0d, got %0d",
								$realtime, want, flow_bus.flow_sum);
						mismatches++;
					end
				end
			end
			if (cfg_we) vcount <= cfg_wdata;
			pending = flow_expected.size();
		end
	end
endmodule

// File: dv/max_flow_bfs_augmenting_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// max_flow_bfs_augmenting_test
// Loads capacity matrices under a range of vertex counts (saturating
// values included), with full, short and over-long loads, random sender
// bursts and receiver stalls, and lets the checker compare every total.
// ---------------------------------------------------------------------------
module max_flow_bfs_augmenting_test;
	import mfa_pkg::*;

	localparam int WATCHDOG = 5000000;
	localparam int HOLD_CYC = 2000;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_we = 1'b0;
	logic [VC_W-1:0] cfg_wdata = '0;
	int              mismatches, pending;
	int              hold_req = 0, hold_done = 0;
	int              idle_cycles = 0;
	int              words_sent = 0;
	int              burst_left = 0;
	bit              no_gaps = 0;
	bit              all_written = 0;
	int unsigned     cur_n = 16;

	mfa_item_if   item_bus ();
	mfa_result_if flow_bus ();

	max_flow_bfs_augmenting dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.matrix(item_bus), .result(flow_bus)
	);

	max_flow_bfs_augmenting_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.item_bus(item_bus), .flow_bus(flow_bus),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: stall pattern changes every stretch, plus requested long hold
	initial begin
		int mode, left;
		flow_bus.ready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				flow_bus.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_done++;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 300);
				end
				left--;
				case (mode)
					0: flow_bus.ready <= 1'b1;
					1: flow_bus.ready <= ($urandom_range(0, 1) == 1);
					2: flow_bus.ready <= (left % 4 == 0);
					default: flow_bus.ready <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (flow_bus.valid && flow_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("max_flow_bfs_augmenting_test: FAIL");
			$finish;
		end
	end

	function automatic logic [CAP_IN_W-1:0] rand_cap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return '0;
			4: return 16'hFFFF;
			5: return CAP_IN_W'($urandom_range(1, 15));
			default: return CAP_IN_W'($urandom());
		endcase
	endfunction

	task automatic send_word(input logic [CAP_IN_W-1:0] cap, input logic last);
		if (burst_left == 0) begin
			if (!no_gaps) begin
				item_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		item_bus.valid      <= 1'b1;
		item_bus.capacity   <= cap;
		item_bus.last_entry <= last;
		do @(negedge clk); while (!item_bus.ready);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic end_words();
		item_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every total, then for the block to settle
	task automatic drain();
		do @(negedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_vcount(input logic [VC_W-1:0] vc);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= vc;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_n = (vc < 2) ? 2 : (vc > 16) ? 16 : vc;
		all_written = all_written;
	endtask

	// full, short (early last) or over-long load of one matrix
	task automatic send_matrix(input int kind);
		int len;
		case (kind)
			1: len = $urandom_range(1, cur_n * cur_n - 1);
			2: len = cur_n * cur_n + $urandom_range(1, 5);
			default: len = cur_n * cur_n;
		endcase
		for (int i = 0; i < len; i++) send_word(rand_cap(), i == len - 1);
		if (cur_n == 16 && kind != 1) all_written = 1;
	endtask

	initial begin
		int vc, kinds, cnt;
		item_bus.valid = 1'b0;
		item_bus.capacity = '0;
		item_bus.last_entry = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two vertices, extreme capacities, short and long loads
		write_vcount(5'd2);
		no_gaps = 1;
		send_word(16'h0000, 0); send_word(16'hFFFF, 0);
		send_word(16'hFFFF, 0); send_word(16'h0000, 1);
		send_word(16'h0000, 0); send_word(16'h0000, 0);
		send_word(16'h0000, 0); send_word(16'h0000, 1);
		send_word(16'h0007, 1);
		send_word(16'h0000, 0); send_word(16'h0001, 0); send_word(16'h0001, 0);
		send_word(16'h0000, 0); send_word(16'hAAAA, 0); send_word(16'h5555, 1);
		end_words();
		no_gaps = 0;
		write_vcount(5'd0);
		send_matrix(0);
		send_matrix(1);
		end_words();
		write_vcount(5'd1);
		send_matrix(2);
		end_words();
		write_vcount(5'd31);
		send_matrix(0);
		end_words();

		// random phases; the first one holds the receiver off on small matrices
		cnt = 0;
		while (words_sent < 1050) begin
			case ($urandom_range(0, 19))
				0: vc = $urandom_range(0, 1);
				1: vc = $urandom_range(16, 31);
				2, 3: vc = $urandom_range(9, 15);
				default: vc = $urandom_range(2, 8);
			endcase
			if (vc >= 16 && cnt > 0 && $urandom_range(0, 1)) vc = 5;
			if (cnt == 0) vc = 3;
			write_vcount(vc[VC_W-1:0]);
			no_gaps = ($urandom_range(0, 3) == 0);
			kinds = $urandom_range(2, 6);
			if (cnt == 0) begin
				hold_req++;
				kinds = 6;
			end
			for (int m = 0; m < kinds && words_sent < 1050; m++) begin
				if (!all_written && m == 0) send_matrix(0);
				else if (cur_n >= 9) send_matrix($urandom_range(0, 3) == 0 ? 0 : 1);
				else send_matrix($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2));
			end
			end_words();
			cnt++;
		end

		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("max_flow_bfs_augmenting_test: PASS");
		else
			$display("max_flow_bfs_augmenting_test: FAIL");
		$finish;
	end
endmodule
